[rtl/world_to_screen_projection_defines.svh]
// Assertion macros shared by the projection RTL.
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define WSP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wsp assertion failed");

// Check an implication on every clock edge outside reset.
`define WSP_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("wsp implication failed");

`endif

[rtl/wsp_pkg.sv]
// Shared types, constants and helpers of the world to screen projection.
package wsp_pkg;

  localparam int unsigned NumPairs     = 8;
  localparam int unsigned NumCoef      = 16;
  localparam int unsigned CfgIdxW      = 4;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned CoordW       = 32;
  localparam int unsigned ProdW        = 64;
  localparam int unsigned FlrW         = 48;
  localparam int unsigned SumW         = 50;
  localparam int unsigned IntBits      = 24;
  localparam int unsigned QW           = 40;
  localparam int unsigned DivSteps     = QW;
  localparam int unsigned NdcW         = 42;
  localparam int unsigned HalfW        = 15;
  localparam int unsigned PxW          = 57;

  localparam int unsigned ScreenWidth  = 1920;
  localparam int unsigned ScreenHeight = 1080;

  localparam logic signed [HalfW-1:0] HalfX = HalfW'(ScreenWidth / 2);
  localparam logic signed [HalfW-1:0] HalfY = HalfW'(ScreenHeight / 2);
  localparam logic signed [PxW-1:0]   BaseX = PxW'(longint'(ScreenWidth / 2) * 65536);
  localparam logic signed [PxW-1:0]   BaseY = PxW'(longint'(ScreenHeight / 2) * 65536);

  // 0.1 in Q16.16
  localparam logic signed [SumW-1:0]  WMin  = SumW'(6554);

  localparam logic [CfgDataW-1:0] PairReset [NumPairs] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  // One divider stage: both quotients share the divisor clip w.
  typedef struct packed {
    logic            vld;
    logic            vis;
    logic            neg_x;
    logic            neg_y;
    logic            clamp_x;
    logic            clamp_y;
    logic [SumW-1:0] d;
    logic [SumW-1:0] rx;
    logic [SumW-1:0] ry;
    logic [QW-1:0]   nx;
    logic [QW-1:0]   ny;
    logic [QW-1:0]   qx;
    logic [QW-1:0]   qy;
  } div_t;

  function automatic logic [SumW-1:0] abs_c(logic signed [SumW-1:0] v);
    return v[SumW-1] ? SumW'(-v) : v;
  endfunction

  // Shift in one numerator bit and try to subtract the divisor.
  function automatic logic [SumW+QW-1:0] rem_step(logic [SumW-1:0] r,
                                                  logic [QW-1:0] q,
                                                  logic nb,
                                                  logic [SumW-1:0] d);
    logic [SumW:0] t;
    logic [SumW:0] s;
    t = {r, nb};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {s[SumW-1:0], q[QW-2:0], 1'b1};
    end
    return {t[SumW-1:0], q[QW-2:0], 1'b0};
  endfunction

  function automatic div_t div_step(div_t s);
    div_t o;
    o = s;
    {o.rx, o.qx} = rem_step(s.rx, s.qx, s.nx[QW-1], s.d);
    {o.ry, o.qy} = rem_step(s.ry, s.qy, s.ny[QW-1], s.d);
    o.nx = {s.nx[QW-2:0], 1'b0};
    o.ny = {s.ny[QW-2:0], 1'b0};
    return o;
  endfunction

  function automatic logic signed [CoordW-1:0] sat32(logic signed [PxW-1:0] v);
    if (v > PxW'(64'sh7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -PxW'(64'sh8000_0000)) begin
      return 32'sh8000_0000;
    end
    return v[CoordW-1:0];
  endfunction

endpackage

[rtl/wsp_if.sv]
// Handshake channels for world points and screen results.
interface wsp_in_if;
  import wsp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] world_x;
  logic signed [CoordW-1:0] world_y;
  logic signed [CoordW-1:0] world_z;
  modport source(output valid, world_x, world_y, world_z, input ready);
  modport sink(input valid, world_x, world_y, world_z, output ready);
endinterface

interface wsp_out_if;
  import wsp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     visible;
  logic signed [CoordW-1:0] screen_x;
  logic signed [CoordW-1:0] screen_y;
  modport source(output valid, visible, screen_x, screen_y, input ready);
  modport sink(input valid, visible, screen_x, screen_y, output ready);
endinterface

[rtl/wsp_clip.sv]
// Matrix rows x, y and w: products in one stage, sums in the next.
module wsp_clip import wsp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     vld_i,
  input  logic signed [CoordW-1:0] pt_i [3],
  input  logic signed [CoordW-1:0] coef_i [NumCoef],
  output logic                     vld_o,
  output logic signed [SumW-1:0]   cx_o,
  output logic signed [SumW-1:0]   cy_o,
  output logic signed [SumW-1:0]   cw_o
);

  localparam int unsigned RowBase [3] = '{0, 4, 12};

  logic signed [ProdW-1:0] prod [3][3];
  logic signed [FlrW-1:0]  flr_q [3][3];
  logic signed [SumW-1:0]  sum [3];
  logic                    v1_q;

  // Multiply, keep the floored Q16.16 part
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] = pt_i[c] * coef_i[RowBase[r] + c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          flr_q[r][c] <= prod[r][c][FlrW+15:16];
        end
      end
    end
  end

  // Add products and translation
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SumW'(flr_q[r][0]) + SumW'(flr_q[r][1]) + SumW'(flr_q[r][2])
             + SumW'(coef_i[RowBase[r] + 3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (adv_i) begin
      vld_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cx_o <= sum[0];
      cy_o <= sum[1];
      cw_o <= sum[2];
    end
  end

endmodule

[rtl/wsp_div.sv]
// Pipelined restoring divider: one quotient bit per stage for x and y.
module wsp_div import wsp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   vld_i,
  input  logic signed [SumW-1:0] cx_i,
  input  logic signed [SumW-1:0] cy_i,
  input  logic signed [SumW-1:0] cw_i,
  output div_t                   res_o
);

  div_t            st_q [DivSteps+1];
  div_t            init;
  logic [SumW-1:0] ax;
  logic [SumW-1:0] ay;

  // Set up magnitudes, overflow flags and the leading remainder
  always_comb begin
    ax           = abs_c(cx_i);
    ay           = abs_c(cy_i);
    init.vld     = vld_i;
    init.vis     = (cw_i >= WMin);
    init.neg_x   = cx_i[SumW-1];
    init.neg_y   = cy_i[SumW-1];
    init.d       = cw_i;
    init.clamp_x = (SumW'(ax[SumW-1:IntBits]) >= cw_i);
    init.clamp_y = (SumW'(ay[SumW-1:IntBits]) >= cw_i);
    init.rx      = SumW'(ax[SumW-1:IntBits]);
    init.ry      = SumW'(ay[SumW-1:IntBits]);
    init.nx      = {ax[IntBits-1:0], 16'b0};
    init.ny      = {ay[IntBits-1:0], 16'b0};
    init.qx      = '0;
    init.qy      = '0;
  end

  // Advance all divider stages together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DivSteps; k++) begin
        st_q[k] <= '0;
      end
    end else if (adv_i) begin
      st_q[0] <= init;
      for (int k = 1; k <= DivSteps; k++) begin
        st_q[k] <= div_step(st_q[k-1]);
      end
    end
  end

  assign res_o = st_q[DivSteps];

endmodule

[rtl/wsp_view.sv]
// Viewport mapping: scale by half screen size, offset, saturate.
module wsp_view import wsp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  div_t                     div_i,
  output logic                     vld_o,
  output logic                     visible_o,
  output logic signed [CoordW-1:0] screen_x_o,
  output logic signed [CoordW-1:0] screen_y_o
);

  localparam logic signed [NdcW-1:0] NdcClamp = NdcW'(64'sd1 <<< QW);

  logic signed [NdcW-1:0] ndc_x;
  logic signed [NdcW-1:0] ndc_y;
  logic signed [NdcW-1:0] mag_x;
  logic signed [NdcW-1:0] mag_y;
  logic signed [PxW-1:0]  px_q;
  logic signed [PxW-1:0]  py_q;
  logic                   va_q;
  logic                   vis_q;
  logic signed [PxW-1:0]  sx;
  logic signed [PxW-1:0]  sy;

  // Apply overflow clamp and sign
  always_comb begin
    mag_x = div_i.clamp_x ? NdcClamp : NdcW'(div_i.qx);
    mag_y = div_i.clamp_y ? NdcClamp : NdcW'(div_i.qy);
    ndc_x = div_i.neg_x ? -mag_x : mag_x;
    ndc_y = div_i.neg_y ? -mag_y : mag_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      vld_o <= 1'b0;
    end else if (adv_i) begin
      va_q  <= div_i.vld;
      vld_o <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vis_q <= div_i.vis;
      px_q  <= PxW'(HalfX) * PxW'(ndc_x);
      py_q  <= PxW'(HalfY) * PxW'(ndc_y);
    end
  end

  // Offset and saturate; drop coordinates of hidden points
  always_comb begin
    sx = BaseX + px_q;
    sy = BaseY - py_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      visible_o  <= vis_q;
      screen_x_o <= vis_q ? sat32(sx) : '0;
      screen_y_o <= vis_q ? sat32(sy) : '0;
    end
  end

endmodule

[rtl/world_to_screen_projection.sv]
// Use: world points (x, y, z, signed Q16.16) enter on in_if; one result per
// point leaves on out_if with a visible flag and screen x, y in signed Q16.16.
// The 4x4 matrix is held as eight 64-bit coefficient pairs written through
// cfg_we_i, cfg_idx_i and cfg_wdata_i; indexes beyond seven are ignored.
// Write the matrix only while no item is in flight.
// Register stages: matrix products, matrix sums, divider setup, the forty
// bit-per-stage divider stages, viewport scale and saturation. Throughput is
// one item per cycle while the receiver does not stall; the forty divider
// stages set the depth.
// Reset clears all valid bits and loads the identity matrix.
// When the receiver stalls, every stage holds and in_if.ready drops in the
// same cycle; a bubble in the output register is filled even under stall.
`include "world_to_screen_projection_defines.svh"
module world_to_screen_projection import wsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  wsp_in_if.sink              in_if,
  wsp_out_if.source           out_if
);

  logic [CfgDataW-1:0]      pair_q [NumPairs];
  logic signed [CoordW-1:0] coef [NumCoef];
  logic signed [CoordW-1:0] pt [3];
  logic                     adv;
  logic                     c_vld;
  logic signed [SumW-1:0]   cx;
  logic signed [SumW-1:0]   cy;
  logic signed [SumW-1:0]   cw;
  div_t                     div_res;

  // Hold coefficient pairs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumPairs; k++) begin
        pair_q[k] <= PairReset[k];
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumPairs))) begin
      pair_q[cfg_idx_i[2:0]] <= cfg_wdata_i;
    end
  end

  always_comb begin
    for (int k = 0; k < NumPairs; k++) begin
      coef[2*k]   = pair_q[k][CoordW-1:0];
      coef[2*k+1] = pair_q[k][CfgDataW-1:CoordW];
    end
  end

  // Advance the whole pipe when the output register can move
  assign adv         = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;
  assign pt[0]       = in_if.world_x;
  assign pt[1]       = in_if.world_y;
  assign pt[2]       = in_if.world_z;

  wsp_clip u_clip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (in_if.valid),
    .pt_i   (pt),
    .coef_i (coef),
    .vld_o  (c_vld),
    .cx_o   (cx),
    .cy_o   (cy),
    .cw_o   (cw)
  );

  wsp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (c_vld),
    .cx_i   (cx),
    .cy_i   (cy),
    .cw_i   (cw),
    .res_o  (div_res)
  );

  wsp_view u_view (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .div_i      (div_res),
    .vld_o      (out_if.valid),
    .visible_o  (out_if.visible),
    .screen_x_o (out_if.screen_x),
    .screen_y_o (out_if.screen_y)
  );

  `WSP_ASSERT_IMP(a_hidden_zero, clk_i, rst_ni, out_if.valid && !out_if.visible, out_if.screen_x == '0 && out_if.screen_y == '0)
  `WSP_ASSERT(a_ready_tracks_out, clk_i, rst_ni, in_if.ready == (!out_if.valid || out_if.ready))
  `WSP_ASSERT_IMP(a_stall_holds_div, clk_i, rst_ni, out_if.valid && !out_if.ready, ##1 $stable(div_res))

endmodule

[test/tb_top.sv]
// Self-checking testbench of the world to screen projection pipeline.
module tb_top;
  import wsp_pkg::*;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  typedef struct {
    logic                     visible;
    logic signed [CoordW-1:0] screen_x;
    logic signed [CoordW-1:0] screen_y;
  } pixel_t;

  localparam logic [CfgIdxW-1:0] IdxUnused = CfgIdxW'(NumPairs + 3);
  localparam longint             WFloor    = 6554;
  localparam longint             ClampQ    = longint'(1) << 40;
  localparam longint             ClampInt  = longint'(1) << 24;
  localparam int                 SettleCyc = 60;
  localparam int                 CycLimit  = 400000;
  localparam logic [31:0]        One       = 32'h0001_0000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  wsp_in_if  in_if ();
  wsp_out_if out_if ();

  world_to_screen_projection u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  logic [CfgDataW-1:0] matrix_pairs [NumPairs];
  point_t              pending_points[$];
  pixel_t              expected_pixels[$];
  int                  fail_count;
  int                  cycle_count;
  int                  results_seen;
  bit                  hold_off_done;

  // Clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic longint coef(int k);
    logic [31:0] w;
    w = matrix_pairs[k >> 1][(k & 1) * 32 +: 32];
    return longint'(signed'(w));
  endfunction

  function automatic longint clip_row(int row, longint px, longint py, longint pz);
    int     b;
    longint s;
    b = row * 4;
    s = coef(b + 3);
    s += (px * coef(b)) >>> 16;
    s += (py * coef(b + 1)) >>> 16;
    s += (pz * coef(b + 2)) >>> 16;
    return s;
  endfunction

  // Quotient in Q16.16, truncated toward zero, clamped on a huge integer part
  function automatic longint ndc_of(longint c, longint w);
    logic [127:0] a;
    logic [127:0] q;
    a = (c < 0) ? 128'(-c) : 128'(c);
    if (a / 128'(w) >= 128'(ClampInt)) begin
      q = 128'(ClampQ);
    end else begin
      q = (a << 16) / 128'(w);
    end
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [CoordW-1:0] clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic pixel_t project_point(point_t p);
    pixel_t r;
    longint cx, cy, cw, hw, hh;
    hw = longint'(ScreenWidth / 2);
    hh = longint'(ScreenHeight / 2);
    cx = clip_row(0, p.x, p.y, p.z);
    cy = clip_row(1, p.x, p.y, p.z);
    cw = clip_row(3, p.x, p.y, p.z);
    r.visible  = 1'b0;
    r.screen_x = '0;
    r.screen_y = '0;
    if (cw >= WFloor) begin
      r.visible  = 1'b1;
      r.screen_x = clamp32(hw * 65536 + hw * ndc_of(cx, cw));
      r.screen_y = clamp32(hh * 65536 - hh * ndc_of(cy, cw));
    end
    return r;
  endfunction

  // Driver: offer queued points with random gaps, record accepted ones
  int  send_gap;
  bit  send_burst;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.world_x <= '0;
      in_if.world_y <= '0;
      in_if.world_z <= '0;
      send_gap      <= 0;
      send_burst    <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        point_t acc;
        acc.x = in_if.world_x;
        acc.y = in_if.world_y;
        acc.z = in_if.world_z;
        expected_pixels.push_back(project_point(acc));
      end
      if (send_gap > 0) begin
        send_gap    <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        point_t nxt;
        nxt = pending_points.pop_front();
        in_if.valid   <= 1'b1;
        in_if.world_x <= nxt.x;
        in_if.world_y <= nxt.y;
        in_if.world_z <= nxt.z;
        if ($urandom_range(0, 31) == 0) begin
          send_burst <= ~send_burst;
        end
        send_gap <= send_burst ? 0 : $urandom_range(0, 7);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: random stalls, one long hold-off, compare each result
  int recv_gap;
  int hold_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready  <= 1'b0;
      recv_gap      <= 0;
      results_seen  <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen <= results_seen + 1;
        if (expected_pixels.size() == 0) begin
          $error("result with no expected pixel: visible=%0d x=%0d y=%0d",
                 out_if.visible, out_if.screen_x, out_if.screen_y);
          fail_count++;
        end else begin
          pixel_t e;
          e = expected_pixels.pop_front();
          if (out_if.visible !== e.visible) begin
            $error("visible: expected %0d, got %0d", e.visible, out_if.visible);
            fail_count++;
          end
          if (out_if.screen_x !== e.screen_x) begin
            $error("screen_x: expected %0d, got %0d", e.screen_x, out_if.screen_x);
            fail_count++;
          end
          if (out_if.screen_y !== e.screen_y) begin
            $error("screen_y: expected %0d, got %0d", e.screen_y, out_if.screen_y);
            fail_count++;
          end
        end
      end
      if (hold_cnt > 0) begin
        out_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap     <= recv_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (out_if.valid) begin
          recv_gap <= send_burst ? 0 : $urandom_range(0, 7);
        end
      end
    end
  end

  // Long receiver hold-off, counted once midway through the run
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt      <= 0;
      hold_off_done <= 1'b0;
    end else if (!hold_off_done && results_seen == 400) begin
      hold_off_done <= 1'b1;
      hold_cnt      <= 300;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_pair(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx < NumPairs) begin
      matrix_pairs[idx] = data;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every queued point has come back, then let the pipe empty
  task automatic drain;
    while (pending_points.size() > 0 || in_if.valid || expected_pixels.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_points.push_back(p);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 32'($signed($urandom_range(0, 200000000)) - 100000000);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0:       return $urandom();
      1:       return 32'h0;
      default: return 32'($signed($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  // Load a perspective-like matrix with random terms; w mostly follows z
  task automatic load_random_matrix(bit wild);
    logic [31:0] c [NumCoef];
    for (int k = 0; k < NumCoef; k++) begin
      c[k] = wild ? $urandom() : rand_coef();
    end
    if (!wild) begin
      c[14] = One;
      c[15] = 32'($signed($urandom_range(0, 131072)) - 65536);
    end
    for (int i = 0; i < NumPairs; i++) begin
      write_pair(CfgIdxW'(i), {c[2 * i + 1], c[2 * i]});
    end
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      queue_point(rand_coord(), rand_coord(), rand_coord());
    end
    drain();
  endtask

  initial begin
    fail_count  = 0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    for (int i = 0; i < NumPairs; i++) begin
      matrix_pairs[i] = PairReset[i];
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity matrix: field extremes and sign patterns
    queue_point(32'h0, 32'h0, 32'h0);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_point(One, 32'hFFFF_0000, 32'h0);
    queue_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555);
    drain();

    // w follows z: threshold edges, negative depth, clamped quotient
    write_pair(CfgIdxW'(7), {32'h0, One});
    write_pair(IdxUnused, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_point(One, One, 32'd6553);
    queue_point(One, One, 32'd6554);
    queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd6554);
    queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd6554);
    queue_point(One, 32'hFFFF_0000, 32'hFFFF_0000);
    queue_point(32'h0, 32'h0, 32'h8000_0000);
    queue_point(32'h0010_0000, 32'hFFF0_0000, 32'h0002_0000);
    queue_point(32'h0000_8000, 32'h0000_4000, 32'h7FFF_FFFF);
    queue_point(32'hAAAA_AAAA, 32'h5555_5555, 32'h0100_0000);
    drain();

    // Extreme coefficients everywhere, then an all-zero matrix
    for (int i = 0; i < NumPairs; i++) begin
      write_pair(CfgIdxW'(i), (i % 2) ? 64'h8000_0000_7FFF_FFFF : 64'h7FFF_FFFF_8000_0000);
    end
    run_random(40);
    for (int i = 0; i < NumPairs; i++) begin
      write_pair(CfgIdxW'(i), 64'h0);
    end
    run_random(20);

    // Random matrices, mostly perspective-like
    for (int ph = 0; ph < 8; ph++) begin
      load_random_matrix(ph == 3);
      run_random(120);
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
